/* design/ttcgs_pkg.sv */
`default_nettype none

package ttcgs_pkg;

   localparam int TTC_W      = 15;
   localparam int SPEED_W    = 8;
   localparam int CFG_W      = 14;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;

   localparam int TTC_FRAC_BITS_DEFAULT  = 4;
   localparam int GAIN_FRAC_BITS_DEFAULT = 8;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_TTC    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_SPEED = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_SPEED     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_SPEED    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_UPPER   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LATER_UPPER   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_JUMP      = 3'd6;

   localparam logic [CFG_W-1:0]   RST_TARGET_TTC    = 14'd1040;
   localparam logic [SPEED_W-1:0] RST_INITIAL_SPEED = 8'd60;
   localparam logic [SPEED_W-1:0] RST_MAX_SPEED     = 8'd180;
   localparam logic [SPEED_W-1:0] RST_STOP_SPEED    = 8'd35;
   localparam logic [CFG_W-1:0]   RST_FIRST_UPPER   = 14'd4800;
   localparam logic [CFG_W-1:0]   RST_LATER_UPPER   = 14'd8000;
   localparam logic [CFG_W-1:0]   RST_MAX_JUMP      = 14'd960;

   typedef struct packed {
      logic [CFG_W-1:0]   target_ttc;
      logic [SPEED_W-1:0] max_speed;
      logic [SPEED_W-1:0] stop_speed;
      logic [CFG_W-1:0]   first_upper;
      logic [CFG_W-1:0]   later_upper;
      logic [CFG_W-1:0]   max_jump;
   } cfg_type;

   typedef struct packed {
      logic [SPEED_W-1:0]      speed;
      logic signed [TTC_W-1:0] last_ttc;
      logic                    first_pending;
      logic                    stopped;
   } state_type;

   typedef struct packed {
      logic [SPEED_W-1:0] speed_cmd;
      logic               accepted;
      logic               stop;
   } result_type;

endpackage

`default_nettype wire

/* design/ttcgs_req_if.sv */
`default_nettype none

interface ttcgs_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ttcgs_pkg::TTC_W-1:0]   ttc_q4;

   modport source (output valid, output ttc_q4, input ready);
   modport sink   (input valid, input ttc_q4, output ready);
endinterface

`default_nettype wire

/* design/ttcgs_rsp_if.sv */
`default_nettype none

interface ttcgs_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ttcgs_pkg::SPEED_W-1:0]     speed_cmd;
   logic                              accepted;
   logic                              stop;

   modport source (output valid, output speed_cmd, output accepted, output stop, input ready);
   modport sink   (input valid, input speed_cmd, input accepted, input stop, output ready);
endinterface

`default_nettype wire

/* design/ttcgs_csr_if.sv */
`default_nettype none

interface ttcgs_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [ttcgs_pkg::CSR_IDX_W-1:0]      idx;
   logic [ttcgs_pkg::CSR_DATA_W-1:0]     wdata;

   modport source (output valid, output idx, output wdata, input ready);
   modport sink   (input valid, input idx, input wdata, output ready);
endinterface

`default_nettype wire

/* design/ttcgs_step.sv */
`default_nettype none

module ttcgs_step #(
   parameter int TTC_FRAC_BITS  = ttcgs_pkg::TTC_FRAC_BITS_DEFAULT,
   parameter int GAIN_FRAC_BITS = ttcgs_pkg::GAIN_FRAC_BITS_DEFAULT
) (
   input  wire logic signed [ttcgs_pkg::TTC_W-1:0] ttc,
   input  wire ttcgs_pkg::state_type                state_cur,
   input  wire ttcgs_pkg::cfg_type                  cfg,
   output      ttcgs_pkg::state_type                state_nxt,
   output      ttcgs_pkg::result_type               result
);

   localparam int TTC_W   = ttcgs_pkg::TTC_W;
   localparam int SPEED_W = ttcgs_pkg::SPEED_W;
   localparam int CFG_W   = ttcgs_pkg::CFG_W;
   localparam int SHIFT   = TTC_FRAC_BITS + GAIN_FRAC_BITS;
   localparam int KP_W    = GAIN_FRAC_BITS + 1;
   localparam int ERR_W   = TTC_W + 2;
   localparam int PROD_W  = ERR_W + KP_W;
   localparam int SUM_W   = PROD_W + TTC_FRAC_BITS + 1;
   localparam int QUO_W   = SUM_W - SHIFT;
   localparam int DIF_W   = TTC_W + 1;

   localparam logic signed [KP_W-1:0] KP1 = KP_W'((1 * (2 ** GAIN_FRAC_BITS) + 5) / 10);
   localparam logic signed [KP_W-1:0] KP2 = KP_W'((2 * (2 ** GAIN_FRAC_BITS) + 5) / 10);
   localparam logic signed [KP_W-1:0] KP3 = KP_W'((3 * (2 ** GAIN_FRAC_BITS) + 5) / 10);
   localparam logic signed [KP_W-1:0] KP4 = KP_W'((4 * (2 ** GAIN_FRAC_BITS) + 5) / 10);
   localparam logic signed [KP_W-1:0] KP5 = KP_W'((5 * (2 ** GAIN_FRAC_BITS) + 5) / 10);

   localparam int ONE  = 2 ** TTC_FRAC_BITS;
   localparam int B110 = 110 * ONE;
   localparam int B100 = 100 * ONE;
   localparam int B80  = 80 * ONE;
   localparam int B70  = 70 * ONE;
   localparam int B60  = 60 * ONE;
   localparam int B50  = 50 * ONE;
   localparam int B40  = 40 * ONE;

   logic signed [31:0]        ttc_wide;
   logic signed [KP_W-1:0]    kp;
   logic signed [ERR_W-1:0]   err;
   logic signed [PROD_W-1:0]  prod;
   logic signed [SUM_W-1:0]   base;
   logic signed [SUM_W-1:0]   sum;
   logic [QUO_W-1:0]          quo;
   logic [SPEED_W-1:0]        upd_speed;
   logic                      ttc_pos;
   logic signed [DIF_W-1:0]   dif;
   logic [DIF_W-1:0]          dif_abs;
   logic                      acc;
   logic [SPEED_W-1:0]        speed_new;

   assign ttc_wide = 32'(ttc);

   always_comb begin
      if (ttc_wide >= B110) begin
         kp = KP5;
      end else if (ttc_wide >= B100) begin
         kp = KP4;
      end else if (ttc_wide >= B80) begin
         kp = KP3;
      end else if (ttc_wide >= B70) begin
         kp = KP2;
      end else if (ttc_wide >= B60) begin
         kp = KP1;
      end else if (ttc_wide >= B50) begin
         kp = KP2;
      end else if (ttc_wide >= B40) begin
         kp = KP3;
      end else begin
         kp = KP4;
      end
   end

   assign err  = $signed({{2{ttc[TTC_W-1]}}, ttc}) -
                 $signed({{(ERR_W-CFG_W){1'b0}}, cfg.target_ttc});
   assign prod = kp * err;
   assign base = $signed({{(SUM_W-SPEED_W-SHIFT){1'b0}}, state_cur.speed, {SHIFT{1'b0}}});
   assign sum  = base + $signed({{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod});
   assign quo  = sum[SUM_W-1:SHIFT];

   // negative sum floors at zero; otherwise truncate and clamp
   always_comb begin
      if (sum[SUM_W-1]) begin
         upd_speed = '0;
      end else if (quo > {{(QUO_W-SPEED_W){1'b0}}, cfg.max_speed}) begin
         upd_speed = cfg.max_speed;
      end else begin
         upd_speed = quo[SPEED_W-1:0];
      end
   end

   assign ttc_pos = !ttc[TTC_W-1] && (ttc != '0);
   assign dif     = $signed({ttc[TTC_W-1], ttc}) -
                    $signed({state_cur.last_ttc[TTC_W-1], state_cur.last_ttc});
   assign dif_abs = dif[DIF_W-1] ? DIF_W'(-dif) : DIF_W'(dif);

   always_comb begin
      state_nxt = state_cur;
      acc       = 1'b0;
      speed_new = state_cur.speed;
      result    = '0;
      if (state_cur.stopped) begin
         result.stop = 1'b1;
      end else begin
         if (state_cur.first_pending) begin
            acc = ttc_pos && (ttc[CFG_W-1:0] < cfg.first_upper);
            if (acc) begin
               state_nxt.last_ttc = ttc;
            end
            state_nxt.first_pending = 1'b0;
         end else begin
            acc = ttc_pos && (ttc[CFG_W-1:0] < cfg.later_upper) &&
                  (dif_abs < {{(DIF_W-CFG_W){1'b0}}, cfg.max_jump});
            state_nxt.last_ttc = ttc;
         end
         if (acc) begin
            speed_new = upd_speed;
         end
         state_nxt.speed   = speed_new;
         state_nxt.stopped = (speed_new <= cfg.stop_speed);
         result.accepted   = acc;
         result.stop       = state_nxt.stopped;
         result.speed_cmd  = state_nxt.stopped ? '0 : speed_new;
      end
   end

endmodule

`default_nettype wire

/* design/ttc_gain_scheduled_speed_control.sv */
// Time-to-contact speed controller with a gain schedule.
// req_ch carries one signed Q.4 time-to-contact measurement per frame;
// rsp_ch returns exactly one result per measurement, in order: the speed
// command, whether the measurement passed the gate, and the stop flag.
// csr_ch writes the seven configuration registers by index (0 to 6);
// it is always ready and a write to any other index is dropped. Write
// registers only while no measurement is in flight.
// A result is registered: its measurement is held in the input stage register
// until the result register is free, and its result is then loaded there.
// Throughput: one measurement per cycle while rsp_ch does not stall; the gate,
// gain lookup, one multiply and the clamp all sit between the input stage
// register and the result register, and the speed state loads in the same cycle as the result.
// When rsp_ch stalls, the result register holds and one more measurement
// waits in the input stage; req_ch.ready drops only when both are full.
// Synchronous reset restores the register defaults, loads the speed with
// the initial_speed default, clears the stop and the valid flags of both pipeline registers.
`default_nettype none

module ttc_gain_scheduled_speed_control #(
   parameter int TTC_FRAC_BITS  = ttcgs_pkg::TTC_FRAC_BITS_DEFAULT,
   parameter int GAIN_FRAC_BITS = ttcgs_pkg::GAIN_FRAC_BITS_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ttcgs_req_if.sink   req_ch,
   ttcgs_rsp_if.source rsp_ch,
   ttcgs_csr_if.sink   csr_ch
);

   localparam int TTC_W   = ttcgs_pkg::TTC_W;
   localparam int SPEED_W = ttcgs_pkg::SPEED_W;
   localparam int CFG_W   = ttcgs_pkg::CFG_W;

   ttcgs_pkg::cfg_type     cfg_ff;
   ttcgs_pkg::state_type   state_ff;
   ttcgs_pkg::state_type   state_in;
   ttcgs_pkg::result_type  result_ff;
   ttcgs_pkg::result_type  step_result;

   logic                    stage_valid_ff;
   logic                    stage_valid_in;
   logic signed [TTC_W-1:0] stage_ttc_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    step_go;
   logic                    req_xfer;
   logic                    csr_xfer;

   assign step_go  = stage_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_xfer = req_ch.valid && req_ch.ready;
   assign csr_xfer = csr_ch.valid && csr_ch.ready;

   assign req_ch.ready = !stage_valid_ff || step_go;
   assign csr_ch.ready = 1'b1;

   assign stage_valid_in = req_xfer || (stage_valid_ff && !step_go);
   assign rsp_valid_in   = step_go || (rsp_valid_ff && !rsp_ch.ready);

   ttcgs_step #(
      .TTC_FRAC_BITS  (TTC_FRAC_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_step (
      .ttc       (stage_ttc_ff),
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .state_nxt (state_in),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         stage_ttc_ff <= req_ch.ttc_q4;
      end
      if (step_go) begin
         result_ff <= step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_ttc  <= ttcgs_pkg::RST_TARGET_TTC;
         cfg_ff.max_speed   <= ttcgs_pkg::RST_MAX_SPEED;
         cfg_ff.stop_speed  <= ttcgs_pkg::RST_STOP_SPEED;
         cfg_ff.first_upper <= ttcgs_pkg::RST_FIRST_UPPER;
         cfg_ff.later_upper <= ttcgs_pkg::RST_LATER_UPPER;
         cfg_ff.max_jump    <= ttcgs_pkg::RST_MAX_JUMP;
      end else if (csr_xfer) begin
         unique case (csr_ch.idx)
            ttcgs_pkg::REG_TARGET_TTC:  cfg_ff.target_ttc  <= csr_ch.wdata[CFG_W-1:0];
            ttcgs_pkg::REG_MAX_SPEED:   cfg_ff.max_speed   <= csr_ch.wdata[SPEED_W-1:0];
            ttcgs_pkg::REG_STOP_SPEED:  cfg_ff.stop_speed  <= csr_ch.wdata[SPEED_W-1:0];
            ttcgs_pkg::REG_FIRST_UPPER: cfg_ff.first_upper <= csr_ch.wdata[CFG_W-1:0];
            ttcgs_pkg::REG_LATER_UPPER: cfg_ff.later_upper <= csr_ch.wdata[CFG_W-1:0];
            ttcgs_pkg::REG_MAX_JUMP:    cfg_ff.max_jump    <= csr_ch.wdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.speed         <= ttcgs_pkg::RST_INITIAL_SPEED;
         state_ff.last_ttc      <= '0;
         state_ff.first_pending <= 1'b1;
         state_ff.stopped       <= 1'b0;
      end else if (step_go) begin
         state_ff <= state_in;
      end else if (csr_xfer && (csr_ch.idx == ttcgs_pkg::REG_INITIAL_SPEED) &&
                   state_ff.first_pending && !state_ff.stopped) begin
         // a late initial_speed write still loads the speed before the first frame
         state_ff.speed <= csr_ch.wdata[SPEED_W-1:0];
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.speed_cmd = result_ff.speed_cmd;
   assign rsp_ch.accepted  = result_ff.accepted;
   assign rsp_ch.stop      = result_ff.stop;

endmodule

`default_nettype wire

/* tb/sv/ttc_gain_scheduled_speed_control_test.sv */
`timescale 1ns / 1ps

module ttc_gain_scheduled_speed_control_test;

   localparam int TTC_W         = ttcgs_pkg::TTC_W;
   localparam int SPEED_W       = ttcgs_pkg::SPEED_W;
   localparam int CFG_W         = ttcgs_pkg::CFG_W;
   localparam int CSR_IDX_W     = ttcgs_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W    = ttcgs_pkg::CSR_DATA_W;
   localparam int TTC_FRAC      = ttcgs_pkg::TTC_FRAC_BITS_DEFAULT;
   localparam int GAIN_FRAC     = ttcgs_pkg::GAIN_FRAC_BITS_DEFAULT;
   localparam int PROD_SHIFT    = TTC_FRAC + GAIN_FRAC;
   localparam int FRAME         = 1 << TTC_FRAC;
   localparam int DIRECTED      = 21;
   localparam int RANDOM_FRAMES = 900;
   localparam int CYCLE_LIMIT   = 400000;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   logic clock = 1'b1;
   logic reset = 1'b1;

   ttcgs_req_if req_ch ();
   ttcgs_rsp_if rsp_ch ();
   ttcgs_csr_if csr_ch ();

   ttc_gain_scheduled_speed_control dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #2 clock = 1'b0;
      #2 clock = 1'b1;
   end

   // controller shadow: registers, state and results still owed
   ttcgs_pkg::cfg_type      ctl_cfg;
   ttcgs_pkg::state_type    ctl;
   ttcgs_pkg::result_type   speed_results[$];
   ttcgs_pkg::result_type   due;
   logic signed [TTC_W-1:0] ttc_queue[$];

   int  frames_pushed    = 0;
   int  frames_predicted = 0;
   int  results_checked  = 0;
   int  passed_gate      = 0;
   int  mismatches       = 0;
   int  cycles           = 0;
   int  settings_count   = 0;
   int  send_pct         = 0;
   int  stall_pct        = 0;
   int  walk             = 0;
   int  gap_left         = 0;
   int  stall_left       = 0;
   bit  holding          = 1'b0;
   bit  req_fired        = 1'b0;
   bit  rsp_fired        = 1'b0;
   int  idle_levels[3]   = '{0, 30, 100};
   int  band_walk[14]    = '{639, 640, 799, 800, 959, 960, 1119, 1120,
                             1279, 1280, 1599, 1600, 1759, 1760};

   function automatic int draw_wait(int pct);
      return (int'($urandom_range(0, 99)) < pct) ? int'($urandom_range(0, 18)) : 0;
   endfunction

   function automatic int band_gain(int t);
      int tenths;
      if (t >= 110 * FRAME)      tenths = 5;
      else if (t >= 100 * FRAME) tenths = 4;
      else if (t >= 80 * FRAME)  tenths = 3;
      else if (t >= 70 * FRAME)  tenths = 2;
      else if (t >= 60 * FRAME)  tenths = 1;
      else if (t >= 50 * FRAME)  tenths = 2;
      else if (t >= 40 * FRAME)  tenths = 3;
      else                       tenths = 4;
      return (tenths * (1 << GAIN_FRAC) + 5) / 10;
   endfunction

   function automatic logic [SPEED_W-1:0] stepped_speed(int t);
      longint sum;
      sum = (longint'(ctl.speed) <<< PROD_SHIFT)
          + longint'(band_gain(t)) * longint'(t - int'(ctl_cfg.target_ttc));
      if (sum <= 0) return '0;
      // positive sum, so the shift truncates toward zero
      sum = sum >>> PROD_SHIFT;
      if (sum > longint'(ctl_cfg.max_speed)) return ctl_cfg.max_speed;
      return sum[SPEED_W-1:0];
   endfunction

   task automatic predict_frame(logic signed [TTC_W-1:0] ttc);
      int                    t;
      int                    delta;
      logic                  hit;
      ttcgs_pkg::result_type res;
      t   = int'(ttc);
      hit = 1'b0;
      if (!ctl.stopped) begin
         if (ctl.first_pending) begin
            hit = (t > 0) && (t < int'(ctl_cfg.first_upper));
            if (hit) begin
               ctl.speed    = stepped_speed(t);
               ctl.last_ttc = ttc;
            end
            ctl.first_pending = 1'b0;
         end else begin
            delta = t - int'($signed(ctl.last_ttc));
            if (delta < 0) delta = -delta;
            hit = (t > 0) && (t < int'(ctl_cfg.later_upper))
               && (delta < int'(ctl_cfg.max_jump));
            if (hit) ctl.speed = stepped_speed(t);
            // reference follows every later frame, gated or not
            ctl.last_ttc = ttc;
         end
         if (ctl.speed <= ctl_cfg.stop_speed) ctl.stopped = 1'b1;
      end
      res.speed_cmd = ctl.stopped ? '0 : ctl.speed;
      res.accepted  = hit;
      res.stop      = ctl.stopped;
      if (hit) passed_gate++;
      speed_results = {speed_results, res};
   endtask

   task automatic apply_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         ttcgs_pkg::REG_TARGET_TTC: ctl_cfg.target_ttc = data;
         ttcgs_pkg::REG_INITIAL_SPEED: begin
            // a late write reloads the speed only before the first frame
            if (ctl.first_pending && !ctl.stopped) ctl.speed = data[SPEED_W-1:0];
         end
         ttcgs_pkg::REG_MAX_SPEED:   ctl_cfg.max_speed   = data[SPEED_W-1:0];
         ttcgs_pkg::REG_STOP_SPEED:  ctl_cfg.stop_speed  = data[SPEED_W-1:0];
         ttcgs_pkg::REG_FIRST_UPPER: ctl_cfg.first_upper = data;
         ttcgs_pkg::REG_LATER_UPPER: ctl_cfg.later_upper = data;
         ttcgs_pkg::REG_MAX_JUMP:    ctl_cfg.max_jump    = data;
         default: ;
      endcase
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.idx   <= idx;
      csr_ch.wdata <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      apply_reg(idx, data);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic signed [TTC_W-1:0] to_ttc(int v);
      if (v > 16383) v = 16383;
      if (v < -16384) v = -16384;
      return v[TTC_W-1:0];
   endfunction

   function automatic int noise_ttc();
      logic [TTC_W-1:0] raw;
      raw = TTC_W'($urandom_range(0, (1 << TTC_W) - 1));
      return int'($signed(raw));
   endfunction

   // hand one frame to the driver and hold until its transfer is predicted
   task automatic send_frame(int v);
      ttc_queue = {ttc_queue, to_ttc(v)};
      walk = int'(to_ttc(v));
      frames_pushed++;
      wait (frames_predicted == frames_pushed);
   endtask

   task automatic settle();
      wait (results_checked == frames_pushed);
      repeat (4) @(posedge clock);
   endtask

   // mostly a walk around the setpoint, steered so the speed stays clear of the stop
   function automatic int next_random_ttc();
      int pick;
      int probe;
      int target;
      int lim;
      int mid;
      int cand;
      pick   = int'($urandom_range(0, 99));
      target = int'(ctl_cfg.target_ttc);
      lim    = (ctl_cfg.max_jump > 0) ? int'(ctl_cfg.max_jump) - 1 : 0;
      if (pick < 80) begin
         mid = (int'(ctl_cfg.stop_speed) + int'(ctl_cfg.max_speed)) / 2;
         if (int'(ctl.speed) < mid) cand = target + int'($urandom_range(1, 500));
         else cand = target - int'($urandom_range(0, 500));
         if (cand > walk + lim) cand = walk + int'($urandom_range(0, lim));
         else if (cand < walk - lim) cand = walk - int'($urandom_range(0, lim));
         if (cand < 1) cand = 1;
      end else if (pick < 92) begin
         probe = int'($urandom_range(0, 7));
         case (probe)
            0: cand = int'(ctl_cfg.later_upper) - 1;
            1: cand = int'(ctl_cfg.later_upper);
            2: cand = walk + int'(ctl_cfg.max_jump);
            3: cand = walk - int'(ctl_cfg.max_jump);
            4: cand = walk + lim;
            5: cand = walk - lim;
            6: cand = int'($urandom_range(0, 1));
            default: cand = band_walk[2 * int'($urandom_range(0, 6)) + 1]
                          - int'($urandom_range(0, 1));
         endcase
      end else begin
         cand = noise_ttc();
      end
      return cand;
   endfunction

   task automatic pick_settings(int phase);
      int                 s;
      int                 hi;
      logic [CFG_W-1:0]   tgt;
      logic [CFG_W-1:0]   fup;
      logic [CFG_W-1:0]   lup;
      logic [CFG_W-1:0]   jmp;
      logic [SPEED_W-1:0] mx;
      logic [SPEED_W-1:0] stp;
      logic [SPEED_W-1:0] ini;
      s   = int'(ctl.speed);
      tgt = CFG_W'($urandom_range(400, 2400));
      mx  = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(90, 255));
      hi  = (s > 30) ? s - 30 : 0;
      if (hi > 40) hi = 40;
      stp = SPEED_W'($urandom_range(0, hi));
      fup = CFG_W'($urandom_range(0, 16383));
      lup = ($urandom_range(0, 1) == 0) ? 14'h3FFF : 14'($urandom_range(3000, 16382));
      jmp = CFG_W'($urandom_range(150, 1200));
      ini = SPEED_W'($urandom_range(0, 255));
      case (phase)
         1: tgt = '0;
         2: begin
            jmp = '0;
            fup = '0;
            ini = '0;
         end
         3: begin
            lup = '0;
            fup = '1;
            ini = '1;
         end
         4: begin
            jmp = '1;
            lup = '1;
            mx  = '1;
         end
         default: ;
      endcase
      write_reg(ttcgs_pkg::REG_TARGET_TTC, tgt);
      write_reg(ttcgs_pkg::REG_INITIAL_SPEED, {6'($urandom_range(0, 63)), ini});
      write_reg(ttcgs_pkg::REG_MAX_SPEED, {6'($urandom_range(0, 63)), mx});
      write_reg(ttcgs_pkg::REG_STOP_SPEED, {6'($urandom_range(0, 63)), stp});
      write_reg(ttcgs_pkg::REG_FIRST_UPPER, fup);
      write_reg(ttcgs_pkg::REG_LATER_UPPER, lup);
      write_reg(ttcgs_pkg::REG_MAX_JUMP, jmp);
      if ($urandom_range(0, 3) == 0)
         write_reg(REG_UNUSED, CSR_DATA_W'($urandom_range(0, 16383)));
      send_pct  = idle_levels[$urandom_range(0, 2)];
      stall_pct = idle_levels[$urandom_range(0, 2)];
   endtask

   // frame driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid  <= 1'b0;
         req_ch.ttc_q4 <= '0;
         gap_left = 0;
         holding  = 1'b0;
      end else begin
         if (req_fired) begin
            holding  = 1'b0;
            gap_left = draw_wait(send_pct);
         end
         if (!holding) begin
            if (gap_left > 0) gap_left--;
            else if (ttc_queue.size() > 0) begin
               req_ch.ttc_q4 <= ttc_queue.pop_front();
               holding = 1'b1;
            end
         end
         req_ch.valid <= holding;
      end
   end

   // result sink with random back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_fired) stall_left = draw_wait(stall_pct);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      req_fired = 1'b0;
      rsp_fired = 1'b0;
      cycles++;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_fired = 1'b1;
            if (speed_results.size() == 0) begin
               $error("result transfer with no frame outstanding: speed_cmd %0d",
                      rsp_ch.speed_cmd);
               mismatches++;
            end else begin
               due = speed_results.pop_front();
               if (rsp_ch.speed_cmd !== due.speed_cmd) begin
                  $error("speed_cmd: expected %0d, actual %0d", due.speed_cmd,
                         rsp_ch.speed_cmd);
                  mismatches++;
               end
               if (rsp_ch.accepted !== due.accepted) begin
                  $error("accepted: expected %0b, actual %0b", due.accepted,
                         rsp_ch.accepted);
                  mismatches++;
               end
               if (rsp_ch.stop !== due.stop) begin
                  $error("stop: expected %0b, actual %0b", due.stop, rsp_ch.stop);
                  mismatches++;
               end
               results_checked++;
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            req_fired = 1'b1;
            predict_frame(req_ch.ttc_q4);
            frames_predicted++;
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $error("timed out after %0d cycles with %0d results owed", cycles,
                speed_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : stimulus
      int phase;
      int n;
      csr_ch.valid = 1'b0;
      csr_ch.idx   = '0;
      csr_ch.wdata = '0;
      ctl_cfg.target_ttc  = ttcgs_pkg::RST_TARGET_TTC;
      ctl_cfg.max_speed   = ttcgs_pkg::RST_MAX_SPEED;
      ctl_cfg.stop_speed  = ttcgs_pkg::RST_STOP_SPEED;
      ctl_cfg.first_upper = ttcgs_pkg::RST_FIRST_UPPER;
      ctl_cfg.later_upper = ttcgs_pkg::RST_LATER_UPPER;
      ctl_cfg.max_jump    = ttcgs_pkg::RST_MAX_JUMP;
      ctl.speed           = ttcgs_pkg::RST_INITIAL_SPEED;
      ctl.last_ttc        = '0;
      ctl.first_pending   = 1'b1;
      ctl.stopped         = 1'b0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // load a speed above the clamp before the first frame; upper data bits must drop
      write_reg(ttcgs_pkg::REG_INITIAL_SPEED, 14'h3EFA);
      write_reg(REG_UNUSED, 14'h3FFF);

      // first frame on the bound is rejected, so the next one is gated against zero
      send_frame(int'(ctl_cfg.first_upper));
      send_frame(1);
      send_frame(-16384);
      send_frame(16383);
      send_frame(0);
      foreach (band_walk[i]) send_frame(band_walk[i]);
      send_frame(walk + int'(ctl_cfg.max_jump) - 1);
      send_frame(walk + int'(ctl_cfg.max_jump));

      phase = 0;
      while (frames_pushed < DIRECTED + RANDOM_FRAMES) begin
         settle();
         phase++;
         pick_settings(phase);
         n = int'($urandom_range(30, 60));
         repeat (n) send_frame(next_random_ttc());
      end
      settings_count = phase;

      // latch the stop, either on a rejected frame at the threshold or on a negative sum
      settle();
      send_pct  = 30;
      stall_pct = 30;
      if ($urandom_range(0, 1) == 1) begin
         write_reg(ttcgs_pkg::REG_STOP_SPEED, {6'd0, ctl.speed});
         send_frame(-5);
      end else begin
         write_reg(ttcgs_pkg::REG_TARGET_TTC, '1);
         write_reg(ttcgs_pkg::REG_LATER_UPPER, '1);
         write_reg(ttcgs_pkg::REG_MAX_JUMP, '1);
         write_reg(ttcgs_pkg::REG_STOP_SPEED, '0);
         write_reg(ttcgs_pkg::REG_MAX_SPEED, '0);
         send_frame(1);
         send_frame(2);
      end
      settle();
      write_reg(ttcgs_pkg::REG_INITIAL_SPEED, 14'h00FF);
      repeat (20) send_frame(noise_ttc());

      settle();
      repeat (8) @(posedge clock);
      $display("Checked %0d results from %0d frames over %0d register settings;",
               results_checked, frames_pushed, settings_count + 2);
      $display("%0d passed the gate; stop latched: %0b; sender gaps and result stalls mixed in.",
               passed_gate, ctl.stopped);
      if (mismatches == 0 && speed_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
